### rtl/core/pdxc_pkg.sv
// Shared types and request codes for the partial distance XOR check core.
package pdxc_pkg;

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_CHECK = 2'd2;

   localparam int DIST_BITS   = 6;
   localparam int WEIGHT_BITS = 7;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [9:0]  word_index;
      logic [31:0] word_value;
      logic [3:0]  current_row;
      logic [5:0]  required_pd;
   } req_word_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        passed;
   } rsp_word_type;

endpackage

### rtl/core/pdxc_ram.sv
// Generic single write port RAM with one registered read port.
module pdxc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/core/pdxc_weight.sv
// Popcount of one combined word and compare against the required distance.
module pdxc_weight #(
   parameter int WORD_BITS = 32
) (
   input  logic [WORD_BITS-1:0]           word,
   input  logic [pdxc_pkg::DIST_BITS-1:0] limit,
   output logic                           below
);

   localparam int NB   = (WORD_BITS + 7) / 8;
   localparam int PADW = NB * 8;

   logic [PADW-1:0]                    padded;
   logic [3:0]                         byte_cnt [NB];
   logic [pdxc_pkg::WEIGHT_BITS-1:0]   total;

   assign padded = PADW'(word);

   always_comb begin
      for (int b = 0; b < NB; b++) begin
         byte_cnt[b] = '0;
         for (int k = 0; k < 8; k++) begin
            byte_cnt[b] = byte_cnt[b] + 4'(padded[b*8 + k]);
         end
      end
      total = '0;
      for (int b = 0; b < NB; b++) begin
         total = total + pdxc_pkg::WEIGHT_BITS'(byte_cnt[b]);
      end
   end

   assign below = total < pdxc_pkg::WEIGHT_BITS'(limit);

endmodule

### rtl/core/partial_distance_xor_check_core.sv
// Top level: word store with write, read and partial distance XOR check.
//
// Usage: drive req_word and raise start; the word is taken at a rising edge
// where start is high and busy is low. Every request gives exactly one
// response word on rsp_word, marked by rsp_valid for one cycle; the
// receiver cannot stall, so each response must be taken when shown.
// Writes, unused request types and checks with row 0 or a row past the
// store answer in the cycle after acceptance and leave busy low, so one
// such request can be taken every cycle.
// Reads: busy while in S_READ; the response is registered from the output
// of the registered RAM read port.
// Checks with row r (n = 2^r): S_FIRST loads the pivot word (entry n), then
// entries i = 1..n-1 pass the shared XOR / popcount unit, which reads one
// entry and writes entry n+i each cycle. Busy until i = n-1 or the first
// entry below the required distance; the response shows as busy falls.
// Reset clears the sequencer and the response strobe; store contents are
// undefined until written.
module partial_distance_xor_check_core #(
   parameter int LOG_DEPTH = 10,
   parameter int WORD_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  pdxc_pkg::req_word_type req_word,
   output logic                   busy,
   output logic                   rsp_valid,
   output pdxc_pkg::rsp_word_type rsp_word
);

   localparam int AW    = LOG_DEPTH;
   localparam int DEPTH = 1 << LOG_DEPTH;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_READ  = 4'b0010,
      S_FIRST = 4'b0100,
      S_LOOP  = 4'b1000
   } state_type;

   state_type                      state_ff, state_in;
   logic [AW-1:0]                  n_ff, n_in;
   logic [AW-1:0]                  i_ff, i_in;
   logic [pdxc_pkg::DIST_BITS-1:0] dist_ff, dist_in;
   logic [WORD_BITS-1:0]           pivot_ff, pivot_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   pdxc_pkg::rsp_word_type         rsp_ff, rsp_in;

   logic                 accept;
   logic [AW-1:0]        idx;
   logic [AW-1:0]        n_req;
   logic                 row_ok;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [AW-1:0]        rd_addr;
   logic [WORD_BITS-1:0] rd_data;
   logic [WORD_BITS-1:0] combined;
   logic                 below;

   assign accept   = start && (state_ff == S_IDLE);
   assign idx      = AW'(req_word.word_index);
   assign n_req    = AW'(1) << req_word.current_row;
   assign row_ok   = (req_word.current_row != 4'd0) && (32'(req_word.current_row) < LOG_DEPTH);
   assign combined = rd_data ^ pivot_ff;

   pdxc_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pdxc_weight #(
      .WORD_BITS (WORD_BITS)
   ) u_weight (
      .word  (combined),
      .limit (dist_ff),
      .below (below)
   );

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      dist_in      = dist_ff;
      pivot_in     = pivot_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = idx;
      wr_data      = WORD_BITS'(req_word.word_value);
      rd_addr      = '0;
      case (state_ff)
         S_IDLE: begin
            rd_addr = (req_word.req_type == pdxc_pkg::REQ_CHECK) ? n_req : idx;
            if (accept) begin
               case (req_word.req_type)
                  pdxc_pkg::REQ_WRITE: begin
                     wr_en        = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{read_data: '0, passed: 1'b0};
                  end
                  pdxc_pkg::REQ_READ: begin
                     state_in = S_READ;
                  end
                  pdxc_pkg::REQ_CHECK: begin
                     if (row_ok) begin
                        n_in     = n_req;
                        dist_in  = req_word.required_pd;
                        state_in = S_FIRST;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{read_data: '0,
                                         passed: (req_word.current_row == 4'd0)};
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{read_data: '0, passed: 1'b0};
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{read_data: 32'(rd_data), passed: 1'b0};
            state_in     = S_IDLE;
         end
         S_FIRST: begin
            pivot_in = rd_data;
            rd_addr  = AW'(1);
            i_in     = AW'(1);
            state_in = S_LOOP;
         end
         S_LOOP: begin
            rd_addr = i_ff + AW'(1);
            wr_en   = 1'b1;
            wr_addr = n_ff + i_ff;
            wr_data = combined;
            i_in    = i_ff + AW'(1);
            if (below) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{read_data: '0, passed: 1'b0};
               state_in     = S_IDLE;
            end else if (i_ff == n_ff - AW'(1)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{read_data: '0, passed: 1'b1};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      i_ff     <= i_in;
      dist_ff  <= dist_in;
      pivot_ff <= pivot_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // walk stays inside 1..n-1, so writes never touch the entries it reads
   a_loop_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOP) |-> ((i_ff != '0) && (i_ff < n_ff)))
      else $error("check index out of range");

   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_word.req_type == pdxc_pkg::REQ_READ)) |-> ##2 rsp_valid)
      else $error("read response missing");

   a_check_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_word.req_type == pdxc_pkg::REQ_CHECK) && row_ok)
      |=> (busy && !rsp_valid))
      else $error("check did not start");

   a_pass_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.passed) |-> (rsp_word.read_data == '0))
      else $error("pass response carries data");

endmodule
